// ----- rtl/rpnp_pkg.sv -----
`default_nettype none

package rpnp_pkg;

    localparam int COORD_W    = 12;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int OCTAVES    = 4;
    localparam int LAT_W      = 10;
    localparam int SEED_W     = 17;
    localparam int NOISE_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    localparam int OCT_FREQ [OCTAVES] = '{655, 1311, 2621, 5243};
    localparam int OCT_AMP  [OCTAVES] = '{32768, 19661, 11796, 7078};

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SPACING   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THICKNESS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED     = 3'd5;

    localparam logic [1:0] REGION_PAPER  = 2'd0;
    localparam logic [1:0] REGION_LINE   = 2'd1;
    localparam logic [1:0] REGION_MARGIN = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
    } in_t;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic [1:0]  region_kind;
    } out_t;

    typedef struct packed {
        logic [11:0] line_spacing;
        logic [11:0] margin_left;
        logic [23:0] line_color;
        logic [23:0] margin_color;
        logic [7:0]  line_thickness;
        logic [15:0] noise_seed;
    } cfg_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic               use_noise;
        logic [31:0]        pixel_word;
        logic [1:0]         region_kind;
    } mid_t;

endpackage

`default_nettype wire

// ----- rtl/rpnp_fifo.sv -----
`default_nettype none

module rpnp_fifo
    import rpnp_pkg::*;
#(
    parameter int DEPTH = MID_DEPTH_DEF,
    parameter int W     = 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rpnp_hash.sv -----
`default_nettype none

module rpnp_hash
    import rpnp_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [LAT_W-1:0]          ix,
    input  logic [LAT_W-1:0]          iy,
    input  logic [SEED_W-1:0]         seed,
    output logic signed [NOISE_W-1:0] noise
);

    logic [31:0] n0;
    logic [31:0] n_reg, n1_reg, n2_reg;
    logic [31:0] sq_reg, t_reg, p_reg;
    logic [31:0] m;
    logic signed [NOISE_W-1:0] noise_reg;

    assign n0 = 32'(ix) + 32'(iy) * 32'd57 + 32'(seed) * 32'd131;
    assign m  = (p_reg + 32'd1376312589) & 32'h7FFF_FFFF;

    // five stages: mix, square, polynomial, product, scale
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= (n0 << 13) ^ n0;
            sq_reg    <= n_reg * n_reg;
            n1_reg    <= n_reg;
            t_reg     <= sq_reg * 32'd15731 + 32'd789221;
            n2_reg    <= n1_reg;
            p_reg     <= n2_reg * t_reg;
            noise_reg <= $signed(NOISE_W'(65536)) - $signed({1'b0, m[30:14]});
        end
    end

    assign noise = noise_reg;

endmodule

`default_nettype wire

// ----- rtl/rpnp_front.sv -----
`default_nettype none

module rpnp_front
    import rpnp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  item,
    input  cfg_t cfg,
    input  logic mid_full,
    output logic mid_push,
    output mid_t mid_item
);

    localparam int STAGES = COORD_W;

    logic                en;
    logic [STAGES-1:0]   vld_reg;
    logic [COORD_W-1:0]  x_reg   [STAGES];
    logic [COORD_W-1:0]  y_reg   [STAGES];
    logic [COORD_W-1:0]  rem_reg [STAGES];
    logic [COORD_W-1:0]  rem_next [STAGES];

    assign en   = !mid_full;
    assign full = !en;

    // restoring remainder y mod line_spacing, one bit per stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_div
        logic [COORD_W:0] shifted;
        if (k == 0)
        begin : g_first
            assign shifted = {{COORD_W{1'b0}}, item.y_coord[STAGES-1]};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k] <= item.x_coord;
                    y_reg[k] <= item.y_coord;
                end
            end
        end
        else
        begin : g_rest
            assign shifted = {rem_reg[k-1], y_reg[k-1][STAGES-1-k]};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k] <= x_reg[k-1];
                    y_reg[k] <= y_reg[k-1];
                end
            end
        end
        assign rem_next[k] = (shifted >= {1'b0, cfg.line_spacing})
                           ? COORD_W'(shifted - {1'b0, cfg.line_spacing})
                           : shifted[COORD_W-1:0];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], push};
        end
    end

    logic [COORD_W:0] xx, ml, ls, rr, half;
    logic             outside, is_margin, is_line;

    assign xx   = {1'b0, x_reg[STAGES-1]};
    assign rr   = {1'b0, rem_reg[STAGES-1]};
    assign ml   = {1'b0, cfg.margin_left};
    assign ls   = {1'b0, cfg.line_spacing};
    assign half = (COORD_W + 1)'(cfg.line_thickness[7:1]);

    assign outside   = (32'(x_reg[STAGES-1]) >= 32'(MAX_WIDTH))
                    || (32'(y_reg[STAGES-1]) >= 32'(MAX_HEIGHT));
    assign is_margin = (ml != '0) && (xx + half >= ml) && (xx <= ml + half);
    assign is_line   = (ls != '0) && ((rr <= half) || (rr + half >= ls));

    always_comb
    begin
        mid_item.x_coord     = x_reg[STAGES-1];
        mid_item.y_coord     = y_reg[STAGES-1];
        mid_item.use_noise   = 1'b0;
        mid_item.pixel_word  = '0;
        mid_item.region_kind = REGION_PAPER;
        if (outside)
        begin
            mid_item.pixel_word = '0;
        end
        else if (is_margin)
        begin
            mid_item.pixel_word  = {8'hFF, cfg.margin_color};
            mid_item.region_kind = REGION_MARGIN;
        end
        else if (is_line)
        begin
            mid_item.pixel_word  = {8'hFF, cfg.line_color};
            mid_item.region_kind = REGION_LINE;
        end
        else
        begin
            mid_item.use_noise = 1'b1;
        end
    end

    assign mid_push = vld_reg[STAGES-1] && en;

endmodule

`default_nettype wire

// ----- rtl/rpnp_back.sv -----
`default_nettype none

module rpnp_back
    import rpnp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic mid_empty,
    output logic mid_pop,
    input  mid_t mid_item,
    input  cfg_t cfg,
    input  logic out_full,
    output logic out_push,
    output out_t out_item
);

    localparam int LAST = 13;

    logic            en;
    logic [LAST:0]   vld_reg;
    mid_t            meta_reg [LAST+1];

    assign en      = !out_full;
    assign mid_pop = !mid_empty && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], mid_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= mid_item;
            for (int k = 1; k <= LAST; k++)
            begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    logic signed [19:0] v_reg   [OCTAVES];
    logic signed [36:0] amp_reg [OCTAVES];

    for (genvar i = 0; i < OCTAVES; i++)
    begin : g_oct
        logic [25:0]        pos_x, pos_y;
        logic [LAT_W-1:0]   ix_reg, iy_reg;
        logic [15:0]        fx_reg, fy_reg;
        logic [15:0]        f2x_reg, f2y_reg, fx1_reg, fy1_reg;
        logic [33:0]        smx, smy;
        logic [16:0]        sx_reg [2:5];
        logic [16:0]        sy_reg [2:7];
        logic [SEED_W-1:0]  seed;
        logic signed [NOISE_W-1:0] n00, n10, n01, n11;
        logic signed [NOISE_W:0]   dx0, dx1;
        logic signed [36:0] px0_reg, px1_reg;
        logic signed [NOISE_W-1:0] n00_reg, n01_reg;
        logic signed [19:0] r0_reg, r1_reg, r0d_reg;
        logic signed [20:0] dy;
        logic signed [38:0] py_reg;

        assign pos_x = {14'b0, mid_item.x_coord} * 26'(OCT_FREQ[i]);
        assign pos_y = {14'b0, mid_item.y_coord} * 26'(OCT_FREQ[i]);
        assign seed  = SEED_W'(cfg.noise_seed) + SEED_W'(i);

        rpnp_hash u_h00 (.clk(clk), .en(en), .ix(ix_reg), .iy(iy_reg),
                         .seed(seed), .noise(n00));
        rpnp_hash u_h10 (.clk(clk), .en(en), .ix(ix_reg + 1'b1), .iy(iy_reg),
                         .seed(seed), .noise(n10));
        rpnp_hash u_h01 (.clk(clk), .en(en), .ix(ix_reg), .iy(iy_reg + 1'b1),
                         .seed(seed), .noise(n01));
        rpnp_hash u_h11 (.clk(clk), .en(en), .ix(ix_reg + 1'b1),
                         .iy(iy_reg + 1'b1), .seed(seed), .noise(n11));

        // smoothstep: (f*f >> 16) * (3 - 2f) >> 16
        assign smx = 34'(f2x_reg) * (34'd196608 - {17'b0, fx1_reg, 1'b0});
        assign smy = 34'(f2y_reg) * (34'd196608 - {17'b0, fy1_reg, 1'b0});

        assign dx0 = (NOISE_W + 1)'(n10) - (NOISE_W + 1)'(n00);
        assign dx1 = (NOISE_W + 1)'(n11) - (NOISE_W + 1)'(n01);
        assign dy  = 21'(r1_reg) - 21'(r0_reg);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ix_reg     <= pos_x[25:16];
                iy_reg     <= pos_y[25:16];
                fx_reg     <= pos_x[15:0];
                fy_reg     <= pos_y[15:0];
                f2x_reg    <= 16'((32'(fx_reg) * 32'(fx_reg)) >> 16);
                f2y_reg    <= 16'((32'(fy_reg) * 32'(fy_reg)) >> 16);
                fx1_reg    <= fx_reg;
                fy1_reg    <= fy_reg;
                sx_reg[2]  <= smx[32:16];
                sy_reg[2]  <= smy[32:16];
                for (int k = 3; k <= 5; k++)
                begin
                    sx_reg[k] <= sx_reg[k-1];
                end
                for (int k = 3; k <= 7; k++)
                begin
                    sy_reg[k] <= sy_reg[k-1];
                end
                px0_reg    <= dx0 * $signed({1'b0, sx_reg[5]});
                px1_reg    <= dx1 * $signed({1'b0, sx_reg[5]});
                n00_reg    <= n00;
                n01_reg    <= n01;
                r0_reg     <= 20'(n00_reg) + 20'(px0_reg >>> 16);
                r1_reg     <= 20'(n01_reg) + 20'(px1_reg >>> 16);
                py_reg     <= dy * $signed({1'b0, sy_reg[7]});
                r0d_reg    <= r0_reg;
                v_reg[i]   <= r0d_reg + 20'(py_reg >>> 16);
                amp_reg[i] <= $signed({1'b0, 16'(OCT_AMP[i])}) * v_reg[i];
            end
        end
    end

    logic signed [21:0] fbm_sum;
    logic signed [21:0] fbm_reg;
    logic signed [35:0] pb_reg;
    logic signed [23:0] bright;
    logic [16:0]        ub_reg;
    logic [24:0]        rg_prod, bl_prod;

    always_comb
    begin
        fbm_sum = '0;
        for (int i = 0; i < OCTAVES; i++)
        begin
            fbm_sum = fbm_sum + 22'(amp_reg[i] >>> 16);
        end
    end

    assign bright = 24'sd63898 + 24'(pb_reg >>> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fbm_reg <= fbm_sum;
            pb_reg  <= $signed(14'sd3277) * fbm_reg;
            if (bright < 24'sd58982)
            begin
                ub_reg <= 17'd58982;
            end
            else if (bright > 24'sd65536)
            begin
                ub_reg <= 17'd65536;
            end
            else
            begin
                ub_reg <= 17'(bright);
            end
        end
    end

    assign rg_prod = 25'(ub_reg) * 25'd253;
    assign bl_prod = 25'(ub_reg) * 25'd251;

    always_comb
    begin
        out_item.region_kind = meta_reg[LAST].region_kind;
        if (meta_reg[LAST].use_noise)
        begin
            out_item.pixel_word = {8'hFF, rg_prod[23:16], rg_prod[23:16], bl_prod[23:16]};
        end
        else
        begin
            out_item.pixel_word = meta_reg[LAST].pixel_word;
        end
    end

    assign out_push = vld_reg[LAST] && en;

endmodule

`default_nettype wire

// ----- rtl/ruled_paper_noise_pixel.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------
// input    | push / full           | item   (x_coord, y_coord)
// result   | pop / empty           | result (pixel_word, region_kind)
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per clock sustained while results are popped. The front has
// 12 remainder stages, one per coordinate bit, and the back 14 noise
// stages, each followed by a queue. Reset clears queues and stage valids
// only; configuration registers take their reset values. A full result
// queue stalls the back, and a full middle queue stalls the front.
`default_nettype none

module ruled_paper_noise_pixel
    import rpnp_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_t                   item,
    output logic                  empty,
    input  logic                  pop,
    output out_t                  result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_spacing   <= '0;
            cfg_reg.margin_left    <= '0;
            cfg_reg.line_color     <= '0;
            cfg_reg.margin_color   <= '0;
            cfg_reg.line_thickness <= 8'd1;
            cfg_reg.noise_seed     <= 16'd42;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINE_SPACING:   cfg_reg.line_spacing   <= cfg_data[11:0];
                CFG_MARGIN_LEFT:    cfg_reg.margin_left    <= cfg_data[11:0];
                CFG_LINE_COLOR:     cfg_reg.line_color     <= cfg_data[23:0];
                CFG_MARGIN_COLOR:   cfg_reg.margin_color   <= cfg_data[23:0];
                CFG_LINE_THICKNESS: cfg_reg.line_thickness <= cfg_data[7:0];
                CFG_NOISE_SEED:     cfg_reg.noise_seed     <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    logic mid_full, mid_empty, mid_push, mid_pop;
    mid_t mid_in, mid_out;
    logic out_full, out_push;
    out_t out_in;

    rpnp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cfg      (cfg_reg),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_item (mid_in)
    );

    rpnp_fifo #(.DEPTH(MID_DEPTH), .W($bits(mid_t))) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (mid_in),
        .rd_en   (mid_pop),
        .rd_data (mid_out),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    rpnp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_item  (mid_out),
        .cfg       (cfg_reg),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_in)
    );

    rpnp_fifo #(.DEPTH(OUT_DEPTH), .W($bits(out_t))) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_in),
        .rd_en   (pop),
        .rd_data (result),
        .full    (out_full),
        .empty   (empty)
    );

endmodule

`default_nettype wire

// ----- tb/rpnp_checker.sv -----
`timescale 1ns / 1ps

module rpnp_checker
    import rpnp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  in_t                   item,
    input  logic                  empty,
    input  logic                  pop,
    input  out_t                  result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    cfg_t regs;
    out_t pixel_q[$];

    function automatic longint lattice_val(bit [31:0] ix, bit [31:0] iy, bit [31:0] seed);
        bit [31:0] n;
        bit [31:0] m;
        n = ix + iy * 32'd57 + seed * 32'd131;
        n = (n << 13) ^ n;
        m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7FFF_FFFF;
        return 64'sd65536 - longint'(m >> 14);
    endfunction

    function automatic longint smooth_w(bit [31:0] f);
        longint f2;
        f2 = (longint'(f) * longint'(f)) >>> 16;
        return (f2 * (64'sd196608 - 2 * longint'(f))) >>> 16;
    endfunction

    // arithmetic shift gives floor division for negative products
    function automatic longint lerp_w(longint a, longint b, longint s);
        return a + (((b - a) * s) >>> 16);
    endfunction

    function automatic longint value_noise(bit [31:0] px, bit [31:0] py, bit [31:0] seed);
        bit [31:0] ix;
        bit [31:0] iy;
        longint sx, sy, r0, r1;
        ix = px >> 16;
        iy = py >> 16;
        sx = smooth_w(px & 32'hFFFF);
        sy = smooth_w(py & 32'hFFFF);
        r0 = lerp_w(lattice_val(ix, iy, seed), lattice_val(ix + 1, iy, seed), sx);
        r1 = lerp_w(lattice_val(ix, iy + 1, seed), lattice_val(ix + 1, iy + 1, seed), sx);
        return lerp_w(r0, r1, sy);
    endfunction

    function automatic out_t predict_pixel(in_t px);
        out_t o;
        int thick, half, xi, yi, ml, ls, r;
        bit on_margin, on_line;
        longint grain, bright;
        bit [31:0] rg, bl;
        xi = px.x_coord;
        yi = px.y_coord;
        ml = regs.margin_left;
        ls = regs.line_spacing;
        thick = (regs.line_thickness == 0) ? 1 : regs.line_thickness;
        half = thick / 2;
        on_margin = ml > 0 && xi >= ml - half && xi <= ml + half;
        on_line = 0;
        if (ls > 0)
        begin
            r = yi % ls;
            on_line = r <= half || r >= ls - half;
        end
        if (xi >= MAX_WIDTH || yi >= MAX_HEIGHT)
        begin
            o.pixel_word = 32'd0;
            o.region_kind = REGION_PAPER;
        end
        else if (on_margin)
        begin
            o.pixel_word = {8'hFF, regs.margin_color};
            o.region_kind = REGION_MARGIN;
        end
        else if (on_line)
        begin
            o.pixel_word = {8'hFF, regs.line_color};
            o.region_kind = REGION_LINE;
        end
        else
        begin
            grain = 0;
            for (int i = 0; i < OCTAVES; i++)
                grain += (longint'(OCT_AMP[i]) *
                          value_noise(32'(xi) * 32'(OCT_FREQ[i]), 32'(yi) * 32'(OCT_FREQ[i]),
                                      32'(regs.noise_seed) + 32'(i))) >>> 16;
            bright = 64'sd63898 + ((64'sd3277 * grain) >>> 16);
            if (bright < 58982) bright = 58982;
            if (bright > 65536) bright = 65536;
            rg = (32'hFD * 32'(bright)) >> 16;
            bl = (32'hFB * 32'(bright)) >> 16;
            o.pixel_word = {8'hFF, rg[7:0], rg[7:0], bl[7:0]};
            o.region_kind = REGION_PAPER;
        end
        return o;
    endfunction

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            regs <= '{line_spacing: 12'd0, margin_left: 12'd0, line_color: 24'd0,
                      margin_color: 24'd0, line_thickness: 8'd1, noise_seed: 16'd42};
            pixel_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pixel_q.size() == 0)
                    report($sformatf("unexpected pixel %h", result));
                else
                begin
                    want = pixel_q.pop_front();
                    if (result.pixel_word !== want.pixel_word)
                        report($sformatf("pixel_word %h, want %h",
                                         result.pixel_word, want.pixel_word));
                    if (result.region_kind !== want.region_kind)
                        report($sformatf("region_kind %0d, want %0d",
                                         result.region_kind, want.region_kind));
                end
            end
            if (push && !full)
                pixel_q.push_back(predict_pixel(item));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LINE_SPACING:   regs.line_spacing   <= cfg_data[11:0];
                    CFG_MARGIN_LEFT:    regs.margin_left    <= cfg_data[11:0];
                    CFG_LINE_COLOR:     regs.line_color     <= cfg_data[23:0];
                    CFG_MARGIN_COLOR:   regs.margin_color   <= cfg_data[23:0];
                    CFG_LINE_THICKNESS: regs.line_thickness <= cfg_data[7:0];
                    CFG_NOISE_SEED:     regs.noise_seed     <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        pending = pixel_q.size();
    end

endmodule

// ----- tb/tb_ruled_paper_noise_pixel.sv -----
`timescale 1ns / 1ps

module tb_ruled_paper_noise_pixel;
    import rpnp_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_t                   item;
    logic                  empty;
    logic                  pop;
    out_t                  result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int send_idle;
    int pop_stall;
    int hold_cycles;
    int quiet_cycles;

    int sp_rows[] = '{0, 29, 30, 31, 32, 33, 34, 35, 4095};

    ruled_paper_noise_pixel dut (.*);

    rpnp_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            pop <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            pop <= $urandom_range(99) >= pop_stall;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(int x, int y);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= '{x_coord: COORD_W'(x), y_coord: COORD_W'(y)};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_paper(int spacing, int margin, int lcol, int mcol, int thick, int seed);
        write_reg(CFG_LINE_SPACING, CFG_DATA_W'(spacing));
        write_reg(CFG_MARGIN_LEFT, CFG_DATA_W'(margin));
        write_reg(CFG_LINE_COLOR, CFG_DATA_W'(lcol));
        write_reg(CFG_MARGIN_COLOR, CFG_DATA_W'(mcol));
        write_reg(CFG_LINE_THICKNESS, CFG_DATA_W'(thick));
        write_reg(CFG_NOISE_SEED, CFG_DATA_W'(seed));
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle = 0;  pop_stall = 0;  end
            1: begin send_idle = 73; pop_stall = 0;  end
            2: begin send_idle = 0;  pop_stall = 73; end
            default: begin send_idle = 17; pop_stall = 17; end
        endcase
    endtask

    function automatic int pick(int a, int b, int c, int d);
        case ($urandom_range(4))
            0: return a;
            1: return b;
            2: return c;
            3: return d;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int sp, ml, th, x, y;
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pop = 1'b0;
        hold_cycles = 0;
        quiet_cycles = 0;
        send_idle = 0;
        pop_stall = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults after reset: all paper
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(12'hAAA, 12'h555);
        wait_drained();

        set_paper(32, 80, 24'h1234AB, 24'hFF0055, 3, 0);
        write_reg(3'd6, 24'hFFFFFF);   // unused indexes are ignored
        write_reg(3'd7, 24'h000001);
        foreach (sp_rows[i]) send_pixel(200, sp_rows[i]);
        for (int i = 78; i <= 82; i++) send_pixel(i, 32);
        wait_drained();

        // zero thickness, spacing one, margin at the far edge
        set_paper(1, 4095, 24'hFFFFFF, 24'h000000, 0, 65535);
        send_pixel(4094, 7);
        send_pixel(4095, 4095);
        send_pixel(10, 10);
        wait_drained();

        // wide half: line band round each multiple of the spacing, margin band past column zero
        set_paper(4095, 1, 24'h00FF00, 24'hFFFFFF, 255, 42);
        send_pixel(0, 1000);
        send_pixel(200, 3000);
        send_pixel(128, 0);
        send_pixel(1000, 2000);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            sp = pick(0, 1, 4095, $urandom_range(2, 64));
            ml = pick(0, 1, 4095, $urandom_range(4095));
            th = pick(0, 1, 255, $urandom_range(2, 8));
            set_paper(sp, ml, $urandom(), $urandom(), th, $urandom());
            set_idling(ph % 4);
            if (ph == 5)
                hold_cycles = 300;
            for (int i = 0; i < 190; i++)
            begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
                if ($urandom_range(3) == 0 && ml > 0) x = ml + $urandom_range(8) - 4;
                if ($urandom_range(3) == 0 && sp > 0) y = sp * $urandom_range(8) + $urandom_range(4) - 2;
                send_pixel(x & 12'hFFF, y & 12'hFFF);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
